// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the line editor RTL.
// Clock clk and reset arst_n must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LEIB_ASSERT_NOW(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("line editor check failed");
`define LEIB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line editor check failed");
`else
`define LEIB_ASSERT_NOW(name, expr)
`define LEIB_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/core/leib_pkg.sv -----
// Shared types and key codes for the line editing input buffer.
// No dependencies.
`default_nettype none
package leib_pkg;

	localparam int DEFAULT_DEPTH = 128;

	localparam logic [8:0] KEY_BS    = 9'h100;
	localparam logic [8:0] KEY_LEFT  = 9'h0E4;
	localparam logic [8:0] KEY_RIGHT = 9'h0E5;
	localparam logic [7:0] CTL_D     = 8'h04;
	localparam logic [7:0] CTL_H     = 8'h08;
	localparam logic [7:0] CTL_P     = 8'h10;
	localparam logic [7:0] CTL_U     = 8'h15;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DUMP,
		OP_KILL,
		OP_BKSP,
		OP_RIGHT,
		OP_LEFT,
		OP_INSERT,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ECHO_NONE  = 3'd0,
		ECHO_CHAR  = 3'd1,
		ECHO_ERASE = 3'd2,
		ECHO_RIGHT = 3'd3,
		ECHO_LEFT  = 3'd4
	} echo_t;

	typedef enum logic [2:0] {
		RS_EMPTY    = 3'd0,
		RS_CHAR     = 3'd1,
		RS_NEWLINE  = 3'd2,
		RS_EOF      = 3'd3,
		RS_EOF_KEPT = 3'd4
	} rstat_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ins_char;
		logic       ins_commit;
	} key_dec_t;

	typedef struct packed {
		echo_t      echo_kind;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_committed;
		logic       dump_request;
		rstat_t     read_status;
		logic [7:0] read_char;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/core/leib_key_decode.sv -----
// Key decoder: classifies an input beat into an edit operation.
// Depends on leib_pkg.
`default_nettype none
module leib_key_decode (
	input  wire logic               mode,
	input  wire logic [8:0]         key_code,
	output leib_pkg::key_dec_t      dec
);
	import leib_pkg::*;

	always_comb begin
		dec = '0;
		dec.op = OP_NONE;
		dec.ins_char = (key_code[7:0] == CH_CR) ? CH_NL : key_code[7:0];
		dec.ins_commit = (dec.ins_char == CH_NL) || (dec.ins_char == CTL_D);
		if (mode) begin
			dec.op = OP_READ;
		end else begin
			case (key_code)
				{1'b0, CTL_P}: dec.op = OP_DUMP;
				{1'b0, CTL_U}: dec.op = OP_KILL;
				{1'b0, CTL_H}, KEY_BS: dec.op = OP_BKSP;
				KEY_RIGHT: dec.op = OP_RIGHT;
				KEY_LEFT: dec.op = OP_LEFT;
				default: begin
					if (key_code != 9'd0 && !key_code[8])
						dec.op = OP_INSERT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/line_editing_input_buffer.sv -----
// Line editing input buffer: key sequencer, circular character store, result register.
// Depends on leib_pkg, leib_key_decode and assert_macros.svh.
//
// Input beats (s_*): s_tuser selects a keystroke (0) or a read of one committed
// character (1). Every input beat yields exactly one result beat on m_*.
// Keystrokes edit the open line held in a single-port-write, one-read store of
// BUFFER_DEPTH characters with a registered read; reads pop committed text.
// Dump, kill, cursor moves and newline/end-of-file go straight to the
// result state; a read first fetches its character from the store. Insert
// and delete move the tail of the open line one entry per cycle through
// the store, which has a single write port.
// One beat is worked on at a time; s_tready is high while no beat is in work.
// The result sits in an output register, so the next beat is accepted while
// m_tvalid waits on a stalled m_tready; a second result waits until it drains.
// Reset clears the read, commit, end and cursor pointers and the output valid; the store needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module line_editing_input_buffer #(
	parameter int BUFFER_DEPTH = leib_pkg::DEFAULT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // key_code[8:0], continuing_request[9]
	input  wire logic [0:0]  s_tuser,   // mode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // echo_char[7:0], erase_count[15:8],
	                                    // line_committed[16], dump_request[17],
	                                    // read_char[25:18]
	output logic [5:0]       m_tuser    // echo_kind[2:0], read_status[5:3]
);
	import leib_pkg::*;

	localparam int PW = $clog2(2 * BUFFER_DEPTH);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
	localparam logic [PW-1:0] PMAX = PW'(2 * BUFFER_DEPTH - 1);
	localparam logic [PW:0] PMOD = (PW + 1)'(2 * BUFFER_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH,
		ST_RD,
		ST_RESP
	} state_t;

	function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
		return (p == PMAX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] p_dec(input logic [PW-1:0] p);
		return (p == '0) ? PMAX : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] p_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] t;
		if (a >= b)
			t = {1'b0, a} - {1'b0, b};
		else
			t = {1'b0, a} + PMOD - {1'b0, b};
		return t[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
		return (p >= DEPTH_P) ? AW'(p - DEPTH_P) : AW'(p);
	endfunction

	state_t          state_q;
	logic [PW-1:0]   read_q, commit_q, end_q, cursor_q;
	logic [PW-1:0]   p_q;
	logic            ins_q;
	logic [7:0]      char_q;
	logic            cont_q;
	res_t            res_q;
	res_t            out_q;
	logic            out_valid_q;
	logic            wr_pend_s1;
	logic [AW-1:0]   wr_addr_s1;
	logic [7:0]      rd_data_s1;
	logic [7:0]      store [BUFFER_DEPTH];

	key_dec_t        dec;
	logic            full;
	logic            full_after;
	logic [PW-1:0]   end_inc;
	logic [PW-1:0]   kill_n;
	logic [PW+7:0]   kill_wide;
	logic [7:0]      kill_cnt;
	logic [PW-1:0]   stop_p, src_p, dst_p, next_p;
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [7:0]      mem_wdata;
	res_t            idle_res;
	state_t          idle_next;
	res_t            rd_res;

	leib_key_decode u_decode (
		.mode     (s_tuser[0]),
		.key_code (s_tdata[8:0]),
		.dec      (dec)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, out_q.read_char, out_q.dump_request, out_q.line_committed,
		out_q.erase_count, out_q.echo_char};
	assign m_tuser = {out_q.read_status, out_q.echo_kind};

	assign end_inc = p_inc(end_q);
	assign full = (p_dist(end_q, read_q) >= DEPTH_P);
	assign full_after = (p_dist(end_inc, read_q) >= DEPTH_P);
	assign kill_n = p_dist(end_q, commit_q);
	assign kill_wide = (PW + 8)'(kill_n);
	assign kill_cnt = (kill_wide > (PW + 8)'(255)) ? 8'hFF : kill_wide[7:0];

	// insert moves the tail up from the end, delete moves it down from the cursor
	assign stop_p = ins_q ? cursor_q : end_q;
	assign src_p = ins_q ? p_dec(p_q) : p_q;
	assign dst_p = ins_q ? p_q : p_dec(p_q);
	assign next_p = ins_q ? p_dec(p_q) : p_inc(p_q);

	// result and next state for a beat taken in idle
	always_comb begin
		idle_res = '0;
		idle_next = ST_RESP;
		case (dec.op)
			OP_DUMP: idle_res.dump_request = 1'b1;
			OP_KILL: begin
				if (kill_n != '0) begin
					idle_res.echo_kind = ECHO_ERASE;
					idle_res.erase_count = kill_cnt;
				end
			end
			OP_BKSP: begin
				if (cursor_q != commit_q) begin
					idle_res.echo_kind = ECHO_ERASE;
					idle_res.erase_count = 8'd1;
					idle_next = ST_SHIFT;
				end
			end
			OP_RIGHT: begin
				if (cursor_q != end_q)
					idle_res.echo_kind = ECHO_RIGHT;
			end
			OP_LEFT: begin
				if (cursor_q != commit_q)
					idle_res.echo_kind = ECHO_LEFT;
			end
			OP_INSERT: begin
				if (!full) begin
					idle_res.echo_kind = ECHO_CHAR;
					idle_res.echo_char = dec.ins_char;
					if (dec.ins_commit)
						idle_res.line_committed = 1'b1;
					else
						idle_next = ST_SHIFT;
				end
			end
			OP_READ: begin
				if (read_q != commit_q)
					idle_next = ST_RD;
			end
			default: ;
		endcase
	end

	always_comb begin
		rd_res = '0;
		if (rd_data_s1 == CTL_D) begin
			rd_res.read_status = cont_q ? RS_EOF_KEPT : RS_EOF;
		end else begin
			rd_res.read_status = (rd_data_s1 == CH_NL) ? RS_NEWLINE : RS_CHAR;
			rd_res.read_char = rd_data_s1;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = slot(end_q);
		mem_wdata = dec.ins_char;
		mem_re = 1'b0;
		mem_raddr = slot(read_q);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && dec.op == OP_INSERT && dec.ins_commit && !full)
					mem_we = 1'b1;
				if (s_tvalid && dec.op == OP_READ && read_q != commit_q)
					mem_re = 1'b1;
			end
			ST_SHIFT: begin
				mem_we = wr_pend_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = rd_data_s1;
				if (p_q != stop_p) begin
					mem_re = 1'b1;
					mem_raddr = slot(src_p);
				end
			end
			ST_FINISH: begin
				if (ins_q) begin
					mem_we = 1'b1;
					mem_waddr = slot(cursor_q);
					mem_wdata = char_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_s1 <= store[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			read_q <= '0;
			commit_q <= '0;
			end_q <= '0;
			cursor_q <= '0;
			out_valid_q <= 1'b0;
			wr_pend_s1 <= 1'b0;
		end else begin
			if (state_q == ST_RESP && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						res_q <= idle_res;
						cont_q <= s_tdata[9];
						state_q <= idle_next;
						case (dec.op)
							OP_KILL: begin
								end_q <= commit_q;
								cursor_q <= commit_q;
							end
							OP_BKSP: begin
								if (cursor_q != commit_q) begin
									p_q <= cursor_q;
									ins_q <= 1'b0;
								end
							end
							OP_RIGHT: begin
								if (cursor_q != end_q)
									cursor_q <= p_inc(cursor_q);
							end
							OP_LEFT: begin
								if (cursor_q != commit_q)
									cursor_q <= p_dec(cursor_q);
							end
							OP_INSERT: begin
								if (!full) begin
									if (dec.ins_commit) begin
										end_q <= end_inc;
										commit_q <= end_inc;
										cursor_q <= end_inc;
									end else begin
										p_q <= end_q;
										ins_q <= 1'b1;
										char_q <= dec.ins_char;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SHIFT: begin
					wr_pend_s1 <= (p_q != stop_p);
					wr_addr_s1 <= slot(dst_p);
					if (p_q != stop_p)
						p_q <= next_p;
					else
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_RESP;
					if (ins_q) begin
						end_q <= end_inc;
						if (full_after) begin
							commit_q <= end_inc;
							cursor_q <= end_inc;
							res_q.line_committed <= 1'b1;
						end else begin
							cursor_q <= p_inc(cursor_q);
						end
					end else begin
						end_q <= p_dec(end_q);
						cursor_q <= p_dec(cursor_q);
					end
				end
				ST_RD: begin
					state_q <= ST_RESP;
					res_q <= rd_res;
					if (!(rd_data_s1 == CTL_D && cont_q))
						read_q <= p_inc(read_q);
				end
				ST_RESP: begin
					if (!out_valid_q || m_tready) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LEIB_ASSERT_NOW(a_fill_bound, p_dist(end_q, read_q) <= DEPTH_P)
	`LEIB_ASSERT_NOW(a_cursor_in_line, p_dist(cursor_q, commit_q) <= p_dist(end_q, commit_q))
	`LEIB_ASSERT_NOW(a_no_write_on_read, !(state_q == ST_RD && mem_we))
	`LEIB_ASSERT_NEXT(a_resp_drains, state_q == ST_RESP && !out_valid_q, out_valid_q)

endmodule
`default_nettype wire
